### hw/rtl/bootloader_frame_deframer_core_macros.svh
// Assertion macros shared by the deframer checker.
// Included by bfd_core_checker.sv; no other dependencies.
`ifndef BOOTLOADER_FRAME_DEFRAMER_CORE_MACROS_SVH
`define BOOTLOADER_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### hw/rtl/bfd_pkg.sv
// Package for the bootloader frame deframer: constants, field layout, CRC-32 step.
// No dependencies.
`default_nettype none

package bfd_pkg;

    localparam int HEADER_BYTES = 18;
    localparam int FILL_W       = 5;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // configuration register indexes
    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] CFG_VERSION      = 2'd2;

    // result kind carried on tuser
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // result tdata layout
    localparam int M_TDATA_W = 96;

    typedef logic [7:0] t_byte;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input t_byte b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bootloader_frame_deframer_core.sv
// Bootloader frame deframer: header window search, field extraction, payload CRC-32.
// Depends on bfd_pkg.
// Window shift and bytewise CRC step are combinational; results are registered.
// Throughput: one byte per cycle while no result is held or m_tready is high.
// Reset: synchronous active-low; clears window fill, payload state, CRC and
// configuration registers; the output register comes up empty.
`default_nettype none

module bootloader_frame_deframer_core #(
    parameter int MAX_CHUNK = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_wdata,
    // byte stream in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    // result stream out
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] command, [39:8] address, [48:40] length, [80:49] frame_crc,
    // [88:81] payload_byte, [89] crc_ok, [95:90] zero
    output logic [bfd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser    // [0] kind
);

    localparam int LEFT_W = $clog2(MAX_CHUNK + 1);
    localparam int HB     = bfd_pkg::HEADER_BYTES;

    logic [7:0] r_magic_first, r_magic_second, r_version;

    bfd_pkg::t_byte r_win [HB];
    bfd_pkg::t_byte n_win [HB];
    logic [bfd_pkg::FILL_W-1:0] r_fill;
    logic                       r_in_payload;
    logic [LEFT_W-1:0]          r_left;
    logic [31:0]                r_crc;

    logic        r_valid;
    logic [7:0]  r_command;
    logic [31:0] r_address;
    logic [8:0]  r_length;
    logic [31:0] r_fcrc_out;
    logic [7:0]  r_payload;
    logic        r_last;
    logic        r_crc_ok;
    logic        r_kind;

    logic        accept;
    logic        win_full;
    logic        hdr_ok;
    logic [31:0] len32;
    logic [31:0] hdr_fcrc;
    logic [31:0] win_fcrc;
    logic [31:0] crc_next;
    logic        pay_last;

    assign s_tready = !r_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < HB - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[HB - 1] = s_tdata;
    end

    assign win_full = (r_fill == bfd_pkg::FILL_W'(HB - 1));
    assign len32    = {n_win[13], n_win[12], n_win[11], n_win[10]};
    assign hdr_fcrc = {n_win[17], n_win[16], n_win[15], n_win[14]};
    assign win_fcrc = {r_win[17], r_win[16], r_win[15], r_win[14]};
    assign hdr_ok   = win_full
                   && (n_win[0] == r_magic_first)
                   && (n_win[1] == r_magic_second)
                   && (n_win[2] == r_version)
                   && (len32 <= 32'(MAX_CHUNK));
    assign crc_next = bfd_pkg::crc32_byte(r_crc, s_tdata);
    assign pay_last = (r_left == LEFT_W'(1));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first  <= '0;
            r_magic_second <= '0;
            r_version      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bfd_pkg::CFG_MAGIC_FIRST:  r_magic_first  <= i_cfg_wdata;
                bfd_pkg::CFG_MAGIC_SECOND: r_magic_second <= i_cfg_wdata;
                bfd_pkg::CFG_VERSION:      r_version      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // header window holds through the payload to supply frame_crc
    always_ff @(posedge i_clk) begin
        if (accept && !r_in_payload) begin
            for (int i = 0; i < HB; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // frame control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_left       <= '0;
            r_crc        <= bfd_pkg::CRC_INIT;
        end else if (accept) begin
            if (r_in_payload) begin
                r_left <= r_left - LEFT_W'(1);
                if (pay_last) begin
                    r_in_payload <= 1'b0;
                    r_fill       <= '0;
                    r_crc        <= bfd_pkg::CRC_INIT;
                end else begin
                    r_crc <= crc_next;
                end
            end else if (!win_full) begin
                r_fill <= r_fill + bfd_pkg::FILL_W'(1);
            end else if (hdr_ok) begin
                r_fill <= '0;
                r_crc  <= bfd_pkg::CRC_INIT;
                if (len32 != 32'd0) begin
                    r_in_payload <= 1'b1;
                    r_left       <= len32[LEFT_W-1:0];
                end
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && (r_in_payload || hdr_ok)) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_in_payload) begin
                r_kind     <= bfd_pkg::KIND_PAYLOAD;
                r_command  <= '0;
                r_address  <= '0;
                r_length   <= '0;
                r_fcrc_out <= '0;
                r_payload  <= s_tdata;
                r_last     <= pay_last;
                r_crc_ok   <= pay_last && ((~crc_next) == win_fcrc);
            end else if (hdr_ok) begin
                r_kind     <= bfd_pkg::KIND_HEADER;
                r_command  <= n_win[3];
                r_address  <= {n_win[9], n_win[8], n_win[7], n_win[6]};
                r_length   <= len32[8:0];
                r_fcrc_out <= hdr_fcrc;
                r_payload  <= '0;
                r_last     <= (len32 == 32'd0);
                r_crc_ok   <= (len32 == 32'd0) && (hdr_fcrc == 32'd0);
            end
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {6'd0, r_crc_ok, r_payload, r_fcrc_out, r_length, r_address, r_command};
    assign m_tlast  = r_last;
    assign m_tuser  = r_kind;

endmodule

`default_nettype wire

### hw/rtl/bfd_core_checker.sv
// Port-level checker for the deframer result stream, bound to the top level.
// Depends on bfd_pkg and bootloader_frame_deframer_core_macros.svh.
`default_nettype none

`include "bootloader_frame_deframer_core_macros.svh"

module bfd_core_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [bfd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire                          m_tlast,
    input wire                          m_tuser
);

    logic                          stalled;
    logic                          hdr_beat;
    logic                          pay_beat;
    logic                          len_zero;
    logic [bfd_pkg::M_TDATA_W+1:0] out_bus;

    assign stalled  = m_tvalid && !m_tready;
    assign hdr_beat = m_tvalid && (m_tuser == bfd_pkg::KIND_HEADER);
    assign pay_beat = m_tvalid && (m_tuser == bfd_pkg::KIND_PAYLOAD);
    assign len_zero = (m_tdata[48:40] == 9'd0);
    assign out_bus  = {m_tdata, m_tlast, m_tuser};

    `BFD_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, stalled, m_tvalid && $stable(out_bus))
    `BFD_ASSERT_IMP(a_header_no_byte, i_clk, i_rst_n, hdr_beat, m_tdata[88:81] == 8'd0)
    `BFD_ASSERT_IMP(a_payload_no_fields, i_clk, i_rst_n, pay_beat, m_tdata[80:0] == 81'd0)
    `BFD_ASSERT_IMP(a_crc_ok_last, i_clk, i_rst_n, m_tvalid && m_tdata[89], m_tlast)
    `BFD_ASSERT_IMP(a_header_last_len, i_clk, i_rst_n, hdr_beat, m_tlast == len_zero)

endmodule

bind bootloader_frame_deframer_core bfd_core_checker u_bfd_core_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### bench/bootloader_frame_deframer_core_tb.sv
// Self-checking bench for bootloader_frame_deframer_core: random and directed byte streams
// checked against a cycle-free predictor of header search, field extraction and payload CRC.
// Depends on bfd_pkg and the core RTL only.
module bootloader_frame_deframer_core_tb;

    localparam int MAX_LEN    = 256;
    localparam int IDLE_LIMIT = 4000;
    localparam int HB         = bfd_pkg::HEADER_BYTES;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic [31:0] address;
        logic [8:0]  length;
        logic [31:0] frame_crc;
        logic [7:0]  payload_byte;
        logic        last;
        logic        crc_ok;
    } t_frame_rec;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [1:0]                    i_cfg_addr  = '0;
    logic [7:0]                    i_cfg_wdata = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [bfd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    bootloader_frame_deframer_core #(.MAX_CHUNK(MAX_LEN)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // match registers as the block should hold them
    logic [7:0] want_magic0 = '0;
    logic [7:0] want_magic1 = '0;
    logic [7:0] want_version = '0;

    // predictor state
    logic [7:0]  hdr_win [HB];
    int          win_fill;
    bit          in_frame;
    int          pay_left;
    logic [31:0] run_crc;

    logic [7:0] rx_bytes [$];
    t_frame_rec pending_results [$];
    t_frame_rec want;
    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_fail     = 0;
    int tx_gap     = 0;
    bit tx_calm    = 1'b0;
    int rx_stall   = 0;
    int rx_hold    = 0;
    int hold_mark  = 30;
    bit rx_calm    = 1'b0;
    int idle_cycles = 0;

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ bfd_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] win_word(input int at);
        return {hdr_win[at + 3], hdr_win[at + 2], hdr_win[at + 1], hdr_win[at]};
    endfunction

    function automatic int next_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // one accepted byte: update the deframer state, queue what it emits
    task automatic deframe_byte(input logic [7:0] b);
        t_frame_rec r;
        logic [31:0] len;
        r = '0;
        if (in_frame) begin
            run_crc = crc_update(run_crc, b);
            if (pay_left > 0) pay_left--;
            r.kind = bfd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            if (pay_left == 0) begin
                r.last = 1'b1;
                r.crc_ok = (~run_crc == win_word(14));
                in_frame = 1'b0;
                win_fill = 0;
                run_crc = bfd_pkg::CRC_INIT;
            end
            pending_results.push_back(r);
        end else begin
            if (win_fill >= HB) win_fill = HB - 1;
            hdr_win[win_fill] = b;
            win_fill++;
            if (win_fill == HB) begin
                len = win_word(10);
                if (hdr_win[0] != want_magic0 || hdr_win[1] != want_magic1 ||
                    hdr_win[2] != want_version || len > MAX_LEN) begin
                    for (int i = 0; i < HB - 1; i++)
                        hdr_win[i] = hdr_win[i + 1];
                    hdr_win[HB - 1] = 8'd0;
                    win_fill = HB - 1;
                end else begin
                    r.kind = bfd_pkg::KIND_HEADER;
                    r.command = hdr_win[3];
                    r.address = win_word(6);
                    r.length = len[8:0];
                    r.frame_crc = win_word(14);
                    run_crc = bfd_pkg::CRC_INIT;
                    if (len == 0) begin
                        r.last = 1'b1;
                        r.crc_ok = (r.frame_crc == 32'd0);
                        win_fill = 0;
                    end else begin
                        in_frame = 1'b1;
                        pay_left = len;
                    end
                    pending_results.push_back(r);
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, got_v);
            n_fail++;
        end
    endfunction

    // byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            win_fill = 0;
            in_frame = 1'b0;
            pay_left = 0;
            run_crc = bfd_pkg::CRC_INIT;
            foreach (hdr_win[i]) hdr_win[i] = 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (rx_bytes.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_bytes.pop_front();
                    tx_gap = next_gap(tx_calm);
                    if ($urandom_range(63, 0) == 0) tx_calm = !tx_calm;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("item with no result pending: tdata %h", m_tdata);
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("command", want.command, m_tdata[7:0]);
                    check_field("address", want.address, m_tdata[39:8]);
                    check_field("length", want.length, m_tdata[48:40]);
                    check_field("frame_crc", want.frame_crc, m_tdata[80:49]);
                    check_field("payload_byte", want.payload_byte, m_tdata[88:81]);
                    check_field("crc_ok", want.crc_ok, m_tdata[89]);
                    check_field("pad", 32'd0, m_tdata[95:90]);
                    check_field("last", want.last, m_tlast);
                end
                n_results++;
            end
            // long hold-off so the block backs up into its input
            if (n_results >= hold_mark && rx_hold == 0) begin
                rx_hold = 150;
                hold_mark += 300;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_stall = ($urandom_range(2, 0) == 0) ? next_gap(rx_calm) : 0;
                if ($urandom_range(63, 0) == 0) rx_calm = !rx_calm;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        rx_bytes.push_back(b);
        n_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [31:0] len_field,
                               input int n_pay, input bit crc_good);
        logic [7:0]  body [$];
        logic [31:0] crc;
        logic [31:0] fcrc;
        logic [31:0] addr;
        crc = bfd_pkg::CRC_INIT;
        for (int i = 0; i < n_pay; i++) begin
            body.push_back(8'($urandom));
            crc = crc_update(crc, body[i]);
        end
        fcrc = ~crc;
        if (!crc_good) fcrc = fcrc ^ (32'd1 << $urandom_range(31, 0));
        addr = $urandom;
        put_byte(b0);
        put_byte(b1);
        put_byte(b2);
        for (int i = 0; i < 3; i++) put_byte(8'($urandom));   // command, two spare bytes
        for (int i = 0; i < 4; i++) put_byte(addr[8*i +: 8]);
        for (int i = 0; i < 4; i++) put_byte(len_field[8*i +: 8]);
        for (int i = 0; i < 4; i++) put_byte(fcrc[8*i +: 8]);
        foreach (body[i]) put_byte(body[i]);
    endtask

    function automatic logic [31:0] pick_len();
        int s;
        s = $urandom_range(99, 0);
        if (s < 10) return 32'd0;
        if (s < 94) return $urandom_range(16, 1);
        if (s < 97) return $urandom_range(255, 200);
        return MAX_LEN;
    endfunction

    // mostly well-formed frames (some with bad CRC), plus noise, bad headers, oversize and cut-short frames
    task automatic random_traffic(input logic [7:0] m0, input logic [7:0] m1,
                                  input logic [7:0] ver, input int n_items);
        int stop_at;
        int pick;
        logic [31:0] len;
        logic [7:0] flip;
        stop_at = n_queued + n_items;
        while (n_queued < stop_at) begin
            pick = $urandom_range(99, 0);
            len = pick_len();
            flip = 8'($urandom_range(255, 1));
            if (pick < 8) begin
                repeat ($urandom_range(6, 1)) put_byte(8'($urandom));
            end else if (pick < 14) begin
                case ($urandom_range(2, 0))
                    0: queue_frame(m0 ^ flip, m1, ver, len, len, 1'b1);
                    1: queue_frame(m0, m1 ^ flip, ver, len, len, 1'b1);
                    default: queue_frame(m0, m1, ver ^ flip, len, len, 1'b1);
                endcase
            end else if (pick < 18) begin
                len = $urandom_range(1, 0) ? 32'd257 : ($urandom | 32'h200);
                queue_frame(m0, m1, ver, len, $urandom_range(8, 0), 1'b1);
            end else if (pick < 21) begin
                len = $urandom_range(16, 2);
                queue_frame(m0, m1, ver, len, $urandom_range(len - 1, 0), 1'b1);
            end else begin
                queue_frame(m0, m1, ver, len, len, $urandom_range(3, 0) != 0);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bfd_pkg::CFG_MAGIC_FIRST:  want_magic0 = val;
            bfd_pkg::CFG_MAGIC_SECOND: want_magic1 = val;
            bfd_pkg::CFG_VERSION:      want_version = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_match(input logic [7:0] m0, input logic [7:0] m1,
                             input logic [7:0] ver);
        write_reg(bfd_pkg::CFG_MAGIC_FIRST, m0);
        write_reg(bfd_pkg::CFG_MAGIC_SECOND, m1);
        write_reg(bfd_pkg::CFG_VERSION, ver);
    endtask

    initial begin
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r2;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset match values: empty frames (good and bad CRC), one-byte frame
        queue_frame(8'h00, 8'h00, 8'h00, 32'd0, 0, 1'b1);
        queue_frame(8'h00, 8'h00, 8'h00, 32'd0, 0, 1'b0);
        queue_frame(8'h00, 8'h00, 8'h00, 32'd1, 1, 1'b1);
        wait_idle();

        // all ones; the unused index must not disturb anything
        set_match(8'hFF, 8'hFF, 8'hFF);
        write_reg(CFG_UNUSED, 8'h00);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 32'd257, 0, 1'b1);
        queue_frame(8'hFF, 8'hFF, 8'hFF, 32'd2, 2, 1'b0);
        random_traffic(8'hFF, 8'hFF, 8'hFF, 260);
        wait_idle();

        set_match(8'hA5, 8'h5A, 8'h01);
        random_traffic(8'hA5, 8'h5A, 8'h01, 260);
        wait_idle();

        r0 = 8'($urandom);
        r1 = 8'($urandom);
        r2 = 8'($urandom);
        set_match(r0, r1, r2);
        random_traffic(r0, r1, r2, 260);
        wait_idle();

        set_match(8'h00, 8'h00, 8'h00);
        random_traffic(8'h00, 8'h00, 8'h00, 260);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (n_fail == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
